[hw/rtl/bart_pkg.sv]
// Shared types, codes and constants for the button auto-repeat tracker.
package bart_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = 2;
    localparam int PIN_W     = 4;
    localparam int THR_W     = 16;
    localparam int CNT_W     = 16;
    localparam int TMR_W     = 32;
    localparam int TOTAL_W   = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [THR_W-1:0] DETECT_RESET = 16'd60;
    localparam logic [THR_W-1:0] DELAY_RESET  = 16'd250;
    localparam logic [THR_W-1:0] REPEAT_RESET = 16'd200;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 3'd7;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DETECT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DELAY  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT = 3'd4;

    typedef struct packed {
        logic             enabled;
        logic [PIN_W-1:0] active;
        logic [THR_W-1:0] detect;
        logic [THR_W-1:0] delay;
        logic [THR_W-1:0] rpt;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic read;
        logic clear;
        logic rpt_clr;
    } chan_ctl_t;

    typedef struct packed {
        logic             pressed;
        logic             released;
        logic             press_ev;
        logic             release_ev;
        logic             rpt_pending;
        logic [CNT_W-1:0] rpt_count;
        logic [TMR_W-1:0] press_tmr;
        logic [TMR_W-1:0] release_tmr;
    } chan_stat_t;

    typedef struct packed {
        logic               is_pressed;
        logic               is_released;
        logic               press_event;
        logic               release_event;
        logic [CNT_W-1:0]   repeat_event_count;
        logic [CNT_W-1:0]   repeat_total;
        logic [TMR_W-1:0]   press_duration;
        logic [TMR_W-1:0]   release_duration;
        logic               pressed_raw;
        logic [TOTAL_W-1:0] pressed_total;
    } res_t;

endpackage

[hw/rtl/bart_regs.sv]
// APB configuration registers of the button auto-repeat tracker.
module bart_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bart_pkg::ADDR_W-1:0]  paddr,
    input  logic [bart_pkg::DATA_W-1:0]  pwdata,
    output logic [bart_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bart_pkg::cfg_t               cfg,
    output logic                         rpt_clr
);

    bart_pkg::cfg_t                   cfg_reg;
    bart_pkg::cfg_t                   cfg_next;
    logic                             wr_en;
    logic [bart_pkg::REG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[bart_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Threshold writes restart repeat tracking, but only while enabled
    assign rpt_clr = wr_en && cfg_reg.enabled &&
                     (idx == bart_pkg::REG_DETECT || idx == bart_pkg::REG_DELAY ||
                      idx == bart_pkg::REG_REPEAT);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                bart_pkg::REG_ENABLE: cfg_next.enabled = pwdata[0];
                bart_pkg::REG_ACTIVE: cfg_next.active  = pwdata[bart_pkg::PIN_W-1:0];
                bart_pkg::REG_DETECT: cfg_next.detect  = pwdata[bart_pkg::THR_W-1:0];
                bart_pkg::REG_DELAY:  cfg_next.delay   = pwdata[bart_pkg::THR_W-1:0];
                bart_pkg::REG_REPEAT: cfg_next.rpt     = pwdata[bart_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bart_pkg::REG_ENABLE: prdata = bart_pkg::DATA_W'(cfg_reg.enabled);
            bart_pkg::REG_ACTIVE: prdata = bart_pkg::DATA_W'(cfg_reg.active);
            bart_pkg::REG_DETECT: prdata = bart_pkg::DATA_W'(cfg_reg.detect);
            bart_pkg::REG_DELAY:  prdata = bart_pkg::DATA_W'(cfg_reg.delay);
            bart_pkg::REG_REPEAT: prdata = bart_pkg::DATA_W'(cfg_reg.rpt);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled <= 1'b1;
            cfg_reg.active  <= '0;
            cfg_reg.detect  <= bart_pkg::DETECT_RESET;
            cfg_reg.delay   <= bart_pkg::DELAY_RESET;
            cfg_reg.rpt     <= bart_pkg::REPEAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/bart_channel.sv]
// State of one button channel: press/release tracking, timers and repeat counting.
module bart_channel
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bart_pkg::chan_ctl_t           ctl,
    input  logic                          pin,
    input  logic                          active,
    input  bart_pkg::cfg_t                cfg,
    output bart_pkg::chan_stat_t          stat
);

    bart_pkg::chan_stat_t           st_reg;
    bart_pkg::chan_stat_t           st_next;
    logic [bart_pkg::CNT_W-1:0]     hold_reg;
    logic [bart_pkg::CNT_W-1:0]     hold_next;
    logic [bart_pkg::CNT_W-1:0]     hold_inc;
    logic [bart_pkg::THR_W-1:0]     thr;
    logic                           down;

    assign down     = (pin == active);
    assign hold_inc = (&hold_reg) ? hold_reg : hold_reg + 1'b1;
    assign stat     = st_reg;

    always_comb
    begin
        if (st_reg.rpt_count == '0)
            thr = cfg.detect;
        else if (st_reg.rpt_count == bart_pkg::CNT_W'(1))
            thr = cfg.delay;
        else
            thr = cfg.rpt;
    end

    always_comb
    begin
        st_next   = st_reg;
        hold_next = hold_reg;
        if (ctl.tick)
        begin
            if (down)
            begin
                if (!st_reg.pressed)
                begin
                    st_next.press_ev  = 1'b1;
                    st_next.press_tmr = '0;
                end
                else if (!(&st_reg.press_tmr))
                begin
                    st_next.press_tmr = st_reg.press_tmr + 1'b1;
                end
                st_next.pressed  = 1'b1;
                st_next.released = 1'b0;
                if (hold_inc >= thr)
                begin
                    hold_next           = '0;
                    st_next.rpt_pending = 1'b1;
                    if (!(&st_reg.rpt_count))
                        st_next.rpt_count = st_reg.rpt_count + 1'b1;
                end
                else
                begin
                    hold_next = hold_inc;
                end
            end
            else
            begin
                if (st_reg.pressed)
                begin
                    st_next.release_ev  = 1'b1;
                    st_next.release_tmr = '0;
                end
                else if (!(&st_reg.release_tmr))
                begin
                    st_next.release_tmr = st_reg.release_tmr + 1'b1;
                end
                st_next.pressed     = 1'b0;
                st_next.released    = 1'b1;
                st_next.rpt_count   = '0;
                st_next.rpt_pending = 1'b0;
                hold_next           = '0;
            end
        end
        if (ctl.read)
        begin
            st_next.press_ev    = 1'b0;
            st_next.release_ev  = 1'b0;
            st_next.rpt_pending = 1'b0;
        end
        if (ctl.clear)
        begin
            st_next.press_tmr   = '0;
            st_next.release_tmr = '0;
            st_next.press_ev    = 1'b0;
            st_next.release_ev  = 1'b0;
        end
        if (ctl.rpt_clr)
        begin
            st_next.rpt_pending = 1'b0;
            st_next.rpt_count   = '0;
            hold_next           = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            hold_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            hold_reg <= hold_next;
        end
    end

endmodule

[hw/rtl/button_auto_repeat_tracker.sv]
// Top level of the button auto-repeat tracker: input stage, channel bank, result stage.
// A transaction accepted into the input register moves its result into the output
// register when it advances, which needs the output register empty or being read.
// Throughput: one transaction per cycle unless stalled; the input register holds one
// more transaction while a result waits, so a stall costs nothing until both are full.
// Reset (rst_n, asynchronous, active low) clears all channel state, both valid
// flags and loads the register reset values; no clearing pass is needed.
module button_auto_repeat_tracker
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [bart_pkg::CH_W-1:0]       channel,
    input  logic [bart_pkg::PIN_W-1:0]      pin_levels,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            is_pressed,
    output logic                            is_released,
    output logic                            press_event,
    output logic                            release_event,
    output logic [bart_pkg::CNT_W-1:0]      repeat_event_count,
    output logic [bart_pkg::CNT_W-1:0]      repeat_total,
    output logic [bart_pkg::TMR_W-1:0]      press_duration,
    output logic [bart_pkg::TMR_W-1:0]      release_duration,
    output logic                            pressed_raw,
    output logic [bart_pkg::TOTAL_W-1:0]    pressed_total,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bart_pkg::ADDR_W-1:0]     paddr,
    input  logic [bart_pkg::DATA_W-1:0]     pwdata,
    output logic [bart_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    bart_pkg::cfg_t                      cfg;
    logic                                rpt_clr;

    logic                                in_valid_reg;
    logic [1:0]                          cmd_reg;
    logic [bart_pkg::CH_W-1:0]           ch_reg;
    logic [bart_pkg::PIN_W-1:0]          pins_reg;

    logic                                out_valid_reg;
    bart_pkg::res_t                      res_reg;
    bart_pkg::res_t                      res_next;

    logic                                advance;
    logic                                in_range;
    logic                                is_read;
    bart_pkg::chan_stat_t                stat   [bart_pkg::CHANNELS];
    bart_pkg::chan_stat_t                sel;
    logic [bart_pkg::TOTAL_W+3:0]        count;
    logic [bart_pkg::TOTAL_W-1:0]        total;

    bart_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .rpt_clr (rpt_clr)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_range = (32'(ch_reg) < bart_pkg::CHANNELS);
    assign is_read  = advance && (cmd_reg == bart_pkg::CMD_READ) && in_range;

    for (genvar i = 0; i < bart_pkg::CHANNELS; i++)
    begin : g_chan
        bart_pkg::chan_ctl_t ctl;
        logic                pin;
        logic                act;

        // channels beyond the pin field always see level 0
        if (i < bart_pkg::PIN_W)
        begin : g_pin
            assign pin = pins_reg[i];
            assign act = cfg.active[i];
        end
        else
        begin : g_nopin
            assign pin = 1'b0;
            assign act = 1'b0;
        end

        assign ctl.tick    = advance && (cmd_reg == bart_pkg::CMD_TICK);
        assign ctl.read    = is_read && cfg.enabled && (32'(ch_reg) == i);
        assign ctl.clear   = advance && (cmd_reg == bart_pkg::CMD_CLEAR) && in_range &&
                             (32'(ch_reg) == i);
        assign ctl.rpt_clr = rpt_clr;

        bart_channel u_chan
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .pin    (pin),
            .active (act),
            .cfg    (cfg),
            .stat   (stat[i])
        );
    end

    assign sel = stat[ch_reg];

    always_comb
    begin
        count = '0;
        for (int i = 0; i < bart_pkg::CHANNELS; i++)
            count = count + (bart_pkg::TOTAL_W+4)'(stat[i].pressed);
        if (count > (bart_pkg::TOTAL_W+4)'(bart_pkg::TOTAL_MAX))
            total = bart_pkg::TOTAL_MAX;
        else
            total = count[bart_pkg::TOTAL_W-1:0];
    end

    always_comb
    begin
        res_next = '0;
        if (is_read)
        begin
            res_next.pressed_raw = sel.pressed;
            if (cfg.enabled)
            begin
                res_next.is_pressed         = sel.pressed;
                res_next.is_released        = sel.released;
                res_next.press_event        = sel.press_ev;
                res_next.release_event      = sel.release_ev;
                res_next.repeat_event_count = sel.rpt_pending ? sel.rpt_count : '0;
                res_next.repeat_total       = sel.rpt_count;
                res_next.press_duration     = sel.press_tmr;
                res_next.release_duration   = sel.release_tmr;
                res_next.pressed_total      = total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg  <= cmd;
            ch_reg   <= channel;
            pins_reg <= pin_levels;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid          = out_valid_reg;
    assign is_pressed         = res_reg.is_pressed;
    assign is_released        = res_reg.is_released;
    assign press_event        = res_reg.press_event;
    assign release_event      = res_reg.release_event;
    assign repeat_event_count = res_reg.repeat_event_count;
    assign repeat_total       = res_reg.repeat_total;
    assign press_duration     = res_reg.press_duration;
    assign release_duration   = res_reg.release_duration;
    assign pressed_raw        = res_reg.pressed_raw;
    assign pressed_total      = res_reg.pressed_total;

endmodule

[hw/rtl/bart_checker.sv]
// Port-level checks for the button auto-repeat tracker, bound to the top level.
module bart_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            is_pressed,
    input  logic                            is_released,
    input  logic [bart_pkg::CNT_W-1:0]      repeat_event_count,
    input  logic [bart_pkg::CNT_W-1:0]      repeat_total,
    input  logic                            pressed_raw,
    input  logic [bart_pkg::TOTAL_W-1:0]    pressed_total
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(repeat_total) &&
        $stable(pressed_total))
        else $error("result changed while stalled");

    a_press_raw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pressed |-> pressed_raw)
        else $error("is_pressed without pressed_raw");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_pressed && is_released))
        else $error("pressed and released together");

    // a pending repeat reports the running count
    a_rpt_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (repeat_event_count != '0) |-> repeat_event_count == repeat_total)
        else $error("repeat event count differs from total");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pressed |-> pressed_total != '0)
        else $error("pressed channel not counted");

endmodule

bind button_auto_repeat_tracker bart_checker u_bart_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .is_pressed         (is_pressed),
    .is_released        (is_released),
    .repeat_event_count (repeat_event_count),
    .repeat_total       (repeat_total),
    .pressed_raw        (pressed_raw),
    .pressed_total      (pressed_total)
);
